// ===== rtl/psm_pkg.sv =====
// Shared field widths and controller-to-datapath command type for the priority scheduler.
package psm_pkg;

  localparam int BURST_IN_W = 16;
  localparam int PRI_W      = 8;
  localparam int ID_W       = 6;
  localparam int TIME_W     = 22;

  typedef struct packed {
    logic we;       // store the incoming beat
    logic clr;      // clear the finish-time accumulator
    logic capture;  // read data holds the process under report
    logic scan;     // read data issued this cycle is a scan entry
  } psm_cmd_t;

endpackage

// ===== rtl/psm_datapath.sv =====
// Process store, scan compare and finish-time accumulator.
module psm_datapath #(
  parameter int MAX_PROCS  = 64,
  parameter int BURST_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  psm_pkg::psm_cmd_t                cmd,
  input  logic [$clog2(MAX_PROCS)-1:0]     wr_addr,
  input  logic [$clog2(MAX_PROCS)-1:0]     rd_addr,
  input  logic [psm_pkg::BURST_IN_W-1:0]   wr_burst,
  input  logic [psm_pkg::PRI_W-1:0]        wr_pri,
  output logic [psm_pkg::TIME_W-1:0]       completion_time,
  output logic [psm_pkg::TIME_W-1:0]       turnaround_time,
  output logic [psm_pkg::TIME_W-1:0]       waiting_time
);
  import psm_pkg::*;

  localparam int IW = $clog2(MAX_PROCS);
  localparam int SB = (BURST_BITS < BURST_IN_W) ? BURST_BITS : BURST_IN_W;
  localparam int EW = SB + PRI_W;

  logic [EW-1:0]     mem [MAX_PROCS];
  logic [EW-1:0]     rd_data_r;
  logic [IW-1:0]     rd_idx_r;
  logic              scan_vld_r;
  logic [SB-1:0]     own_burst_r;
  logic [PRI_W-1:0]  own_pri_r;
  logic [IW-1:0]     own_idx_r;
  logic [TIME_W-1:0] acc_r;

  logic [SB-1:0]     rd_burst;
  logic [PRI_W-1:0]  rd_pri;
  logic              precedes;

  assign rd_burst = rd_data_r[EW-1:PRI_W];
  assign rd_pri   = rd_data_r[PRI_W-1:0];

  // Stable order: lower value first, ties by load index; count the process itself.
  assign precedes = (rd_pri < own_pri_r) ||
                    ((rd_pri == own_pri_r) && (rd_idx_r <= own_idx_r));

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[wr_addr] <= {wr_burst[SB-1:0], wr_pri};
    end
    rd_data_r <= mem[rd_addr];
    rd_idx_r  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
    end else begin
      scan_vld_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      own_burst_r <= rd_burst;
      own_pri_r   <= rd_pri;
      own_idx_r   <= rd_idx_r;
    end
    if (cmd.clr) begin
      acc_r <= '0;
    end else if (scan_vld_r && precedes) begin
      acc_r <= acc_r + TIME_W'(rd_burst);
    end
  end

  assign completion_time = acc_r;
  assign turnaround_time = acc_r;
  assign waiting_time    = acc_r - TIME_W'(own_burst_r);

endmodule

// ===== rtl/psm_ctrl.sv =====
// Load, scan and report sequencer for the priority scheduler.
module psm_ctrl #(
  parameter int MAX_PROCS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           in_last,
  output logic                           busy,
  output psm_pkg::psm_cmd_t              cmd,
  output logic [$clog2(MAX_PROCS)-1:0]   wr_addr,
  output logic [$clog2(MAX_PROCS)-1:0]   rd_addr,
  output logic                           out_valid,
  output logic [psm_pkg::ID_W-1:0]       process_id,
  output logic                           last_result
);
  import psm_pkg::*;

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_CAPT  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [CW-1:0] cnt_m1;
  logic          room;
  logic          i_at_end;

  assign cnt_m1   = cnt_r - CW'(1);
  assign room     = cnt_r < CW'(MAX_PROCS);
  assign i_at_end = CW'(i_r) == cnt_m1;

  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    cmd         = '0;
    rd_addr     = i_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          cmd.we  = room;
          cnt_nxt = cnt_r + CW'(room);
          if (in_last) begin
            i_nxt  = '0;
            st_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.clr = 1'b1;
        j_nxt   = '0;
        st_nxt  = S_CAPT;
      end
      S_CAPT: begin
        cmd.capture = 1'b1;
        cmd.scan    = 1'b1;
        rd_addr     = j_r;
        j_nxt       = j_r + IW'(1);
        st_nxt      = (cnt_m1 == '0) ? S_DRAIN : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        rd_addr  = j_r;
        j_nxt    = j_r + IW'(1);
        if (CW'(j_r) == cnt_m1) begin
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (i_at_end) begin
          cnt_nxt = '0;
          st_nxt  = S_IDLE;
        end else begin
          i_nxt  = i_r + IW'(1);
          st_nxt = S_FETCH;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      i_r   <= '0;
      j_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      i_r   <= i_nxt;
      j_r   <= j_nxt;
    end
  end

  assign wr_addr     = cnt_r[IW-1:0];
  assign busy        = st_r != S_IDLE;
  assign out_valid   = st_r == S_EMIT;
  assign process_id  = ID_W'(i_r);
  assign last_result = out_valid && i_at_end;

`ifndef NO_ASSERTIONS
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on consecutive cycles");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    last_result |=> !busy)
    else $error("block still busy after final result");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last) |=> busy)
    else $error("final beat did not start scheduling");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_PROCS))
    else $error("loaded count beyond store size");
`endif

endmodule

// ===== rtl/priority_schedule_metrics_top.sv =====
// Loading takes one beat per cycle; busy stays low while loading.
// After the beat marked last, each of the N processes is reported after a full scan of the store
// (one store read per entry scanned), so a set takes N scans of N entries to report.
// Results appear one per strobe in id order; the receiver cannot stall the block.
// Reset (synchronous, active low) clears the sequencer, loaded count and scan-valid flag only.
// Top level of the non-preemptive priority scheduler.
module priority_schedule_metrics_top #(
  parameter int MAX_PROCS  = 64,
  parameter int BURST_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [psm_pkg::BURST_IN_W-1:0] in_burst_time,
  input  logic [psm_pkg::PRI_W-1:0]      in_priority_req,
  input  logic                           in_last,
  output logic                           out_valid,
  output logic [psm_pkg::ID_W-1:0]       out_process_id,
  output logic [psm_pkg::TIME_W-1:0]     out_completion_time,
  output logic [psm_pkg::TIME_W-1:0]     out_turnaround_time,
  output logic [psm_pkg::TIME_W-1:0]     out_waiting_time,
  output logic                           out_last_result
);
  import psm_pkg::*;

  localparam int IW = $clog2(MAX_PROCS);

  psm_cmd_t      cmd;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr;

  psm_ctrl #(
    .MAX_PROCS (MAX_PROCS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_last     (in_last),
    .busy        (busy),
    .cmd         (cmd),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .out_valid   (out_valid),
    .process_id  (out_process_id),
    .last_result (out_last_result)
  );

  psm_datapath #(
    .MAX_PROCS  (MAX_PROCS),
    .BURST_BITS (BURST_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .wr_addr         (wr_addr),
    .rd_addr         (rd_addr),
    .wr_burst        (in_burst_time),
    .wr_pri          (in_priority_req),
    .completion_time (out_completion_time),
    .turnaround_time (out_turnaround_time),
    .waiting_time    (out_waiting_time)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the priority scheduler: directed table, then random batches.
`timescale 1ns / 100ps

module testbench;
  import psm_pkg::*;

  localparam int MAX_PROCS      = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int ITEMS_PER_PHASE = 75;

  typedef enum int {BURST_ANY, BURST_MAX, BURST_SMALL, BURST_EDGE} burst_mode_t;
  typedef enum int {PRIO_ANY, PRIO_TIES, PRIO_FIXED} prio_mode_t;

  typedef struct packed {
    logic [ID_W-1:0]   pid;
    logic [TIME_W-1:0] done;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wait_tm;
    logic              fin;
  } sched_result_t;

  typedef struct packed {
    logic [BURST_IN_W-1:0] burst;
    logic [PRI_W-1:0]      prio;
    logic                  last;
    bit                    typed;
    logic [TIME_W-1:0]     done;
    logic [TIME_W-1:0]     wait_tm;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [BURST_IN_W-1:0] in_burst_time;
  logic [PRI_W-1:0]      in_priority_req;
  logic                  in_last;
  logic                  out_valid;
  logic [ID_W-1:0]       out_process_id;
  logic [TIME_W-1:0]     out_completion_time;
  logic [TIME_W-1:0]     out_turnaround_time;
  logic [TIME_W-1:0]     out_waiting_time;
  logic                  out_last_result;

  // scheduler shadow state
  logic [BURST_IN_W-1:0] burst_mem [MAX_PROCS];
  logic [PRI_W-1:0]      prio_mem  [MAX_PROCS];
  int unsigned           loaded_n = 0;
  sched_result_t         batch_q [$];
  sched_result_t         expected_q [$];

  int errors = 0;
  int idle_cycles = 0;

  // single-process sets and extremes carry their results typed in
  stim_row_t dir_tab [16] = '{
    '{16'd0,     8'd0,    1'b1, 1'b1, 22'd0,     22'd0},
    '{16'hFFFF,  8'hFF,   1'b1, 1'b1, 22'd65535, 22'd0},
    '{16'd5,     8'd3,    1'b0, 1'b0, 22'd0,     22'd0},
    '{16'd7,     8'd1,    1'b0, 1'b0, 22'd0,     22'd0},
    '{16'd2,     8'd3,    1'b1, 1'b0, 22'd0,     22'd0},
    '{16'hFFFF,  8'hFF,   1'b0, 1'b0, 22'd0,     22'd0},
    '{16'hFFFF,  8'h00,   1'b0, 1'b0, 22'd0,     22'd0},
    '{16'd1,     8'd128,  1'b1, 1'b0, 22'd0,     22'd0},
    '{16'hAAAA,  8'h55,   1'b0, 1'b0, 22'd0,     22'd0},
    '{16'h5555,  8'hAA,   1'b0, 1'b0, 22'd0,     22'd0},
    '{16'h0000,  8'hFF,   1'b0, 1'b0, 22'd0,     22'd0},
    '{16'hFFFF,  8'h00,   1'b1, 1'b0, 22'd0,     22'd0},
    '{16'd100,   8'd9,    1'b1, 1'b1, 22'd100,   22'd0},
    '{16'd1,     8'd7,    1'b0, 1'b0, 22'd0,     22'd0},
    '{16'd1,     8'd7,    1'b0, 1'b0, 22'd0,     22'd0},
    '{16'd1,     8'd7,    1'b1, 1'b0, 22'd0,     22'd0}
  };

  priority_schedule_metrics_top #(
    .MAX_PROCS  (MAX_PROCS),
    .BURST_BITS (16)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_burst_time       (in_burst_time),
    .in_priority_req     (in_priority_req),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_process_id      (out_process_id),
    .out_completion_time (out_completion_time),
    .out_turnaround_time (out_turnaround_time),
    .out_waiting_time    (out_waiting_time),
    .out_last_result     (out_last_result)
  );

  always #1 clk = ~clk;

  // Load one beat into the shadow store; on last, build the batch of results.
  function automatic void schedule_beat(input logic [BURST_IN_W-1:0] b,
                                        input logic [PRI_W-1:0] p, input logic l);
    int unsigned   run_seq [MAX_PROCS];
    logic [TIME_W-1:0] finish [MAX_PROCS];
    logic [31:0]   clock_acc;
    sched_result_t r;
    int            i;
    int            j;
    batch_q.delete();
    if (loaded_n < MAX_PROCS) begin
      burst_mem[loaded_n] = b;
      prio_mem[loaded_n]  = p;
      loaded_n++;
    end
    if (l) begin
      // stable insertion sort: equal priorities keep load order
      for (i = 0; i < loaded_n; i++) begin
        j = i;
        while (j > 0 && prio_mem[run_seq[j-1]] > prio_mem[i]) begin
          run_seq[j] = run_seq[j-1];
          j--;
        end
        run_seq[j] = i;
      end
      clock_acc = '0;
      for (i = 0; i < loaded_n; i++) begin
        clock_acc = clock_acc + {16'd0, burst_mem[run_seq[i]]};
        finish[run_seq[i]] = clock_acc[TIME_W-1:0];
      end
      for (i = 0; i < loaded_n; i++) begin
        r.pid     = i[ID_W-1:0];
        r.done    = finish[i];
        r.tat     = finish[i];
        r.wait_tm = finish[i] - {6'd0, burst_mem[i]};
        r.fin     = (i + 1 == loaded_n);
        batch_q.push_back(r);
      end
      loaded_n = 0;
    end
  endfunction

  function automatic logic [BURST_IN_W-1:0] pick_burst(input burst_mode_t mode);
    case (mode)
      BURST_MAX:   pick_burst = 16'hFFFF;
      BURST_SMALL: pick_burst = BURST_IN_W'($urandom_range(15));
      BURST_EDGE:  pick_burst = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default:     pick_burst = BURST_IN_W'($urandom);
    endcase
  endfunction

  function automatic logic [PRI_W-1:0] pick_prio(input prio_mode_t mode);
    case (mode)
      PRIO_TIES:  pick_prio = PRI_W'($urandom_range(3));
      PRIO_FIXED: pick_prio = 8'd7;
      default:    pick_prio = PRI_W'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input logic [BURST_IN_W-1:0] b, input logic [PRI_W-1:0] p,
                           input logic l, input int idle_pct,
                           input bit typed, input sched_result_t typed_r);
    while ($urandom_range(99) < idle_pct) begin
      start           <= 1'b0;
      in_burst_time   <= BURST_IN_W'($urandom);
      in_priority_req <= PRI_W'($urandom);
      in_last         <= 1'($urandom_range(1));
      @(negedge clk);
    end
    start           <= 1'b1;
    in_burst_time   <= b;
    in_priority_req <= p;
    in_last         <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    schedule_beat(b, p, l);
    if (typed && l) expected_q.push_back(typed_r);
    else foreach (batch_q[k]) expected_q.push_back(batch_q[k]);
    @(negedge clk);
  endtask

  task automatic send_set(input int n, input burst_mode_t bm, input prio_mode_t pm,
                          input int idle_pct);
    for (int k = 0; k < n; k++)
      send_beat(pick_burst(bm), pick_prio(pm), k == n - 1, idle_pct, 1'b0, '0);
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d got %0d", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    sched_result_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none got id %0d",
                 $time, out_process_id);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("process_id", 32'(e.pid), 32'(out_process_id));
        check_field("completion_time", 32'(e.done), 32'(out_completion_time));
        check_field("turnaround_time", 32'(e.tat), 32'(out_turnaround_time));
        check_field("waiting_time", 32'(e.wait_tm), 32'(out_waiting_time));
        check_field("last_result", 32'(e.fin), 32'(out_last_result));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("priority_schedule_metrics_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sched_result_t tr;
    int ph;
    int idle_pct;
    int sent;
    int n;
    int r;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_burst_time   = '0;
    in_priority_req = '0;
    in_last         = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      tr.pid     = '0;
      tr.done    = dir_tab[i].done;
      tr.tat     = dir_tab[i].done;
      tr.wait_tm = dir_tab[i].wait_tm;
      tr.fin     = 1'b1;
      send_beat(dir_tab[i].burst, dir_tab[i].prio, dir_tab[i].last, 37,
                dir_tab[i].typed, tr);
    end

    for (ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 37 : (ph == 1) ? 79 : 0;
      // one full store per phase: largest times first, then overflow with dropped beats
      if (ph == 0) send_set(MAX_PROCS, BURST_MAX, PRIO_FIXED, idle_pct);
      else send_set(MAX_PROCS + $urandom_range(1, 8), BURST_ANY, PRIO_ANY, idle_pct);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        n = (r < 70) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 20)
                                                      : $urandom_range(21, 40);
        send_set(n, burst_mode_t'($urandom_range(3)), prio_mode_t'($urandom_range(1)),
                 idle_pct);
        sent += n;
      end
      // hold off until the block has reported everything
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clk);
      @(negedge clk);
    end

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("priority_schedule_metrics_top: match");
    end else begin
      $display("priority_schedule_metrics_top: mismatch");
    end
    $finish;
  end

endmodule
